// ===== sv/ws_enc_pkg.sv =====
// Shared types, constants and the bit-expansion function of the WS2812 SPI frame encoder.
package ws_enc_pkg;

    localparam int LED_COUNT        = 64;
    localparam int LEAD_ZERO_BYTES  = 60;
    localparam int TRAIL_ZERO_BYTES = 60;
    localparam int PREAMBLE_BYTES   = 3;
    localparam int LED_W            = $clog2(LED_COUNT);
    localparam int Q_DEPTH          = 2;
    localparam int Q_PTR_W          = $clog2(Q_DEPTH);
    localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);
    localparam int PIX_W            = 24;

    localparam logic [7:0] PREAMBLE_VALUE = 8'hAA;
    localparam logic [4:0] CODE_ONE       = 5'h1C;
    localparam logic [4:0] CODE_ZERO      = 5'h18;
    localparam logic [2:0] LAST_SUB       = 3'd4;
    localparam logic [1:0] LAST_COLOUR    = 2'd2;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SHOW  = 2'd2,
        OP_FETCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_PREAMBLE = 2'd0,
        PH_LEAD     = 2'd1,
        PH_DATA     = 2'd2,
        PH_TRAIL    = 2'd3
    } phase_t;

    typedef struct packed {
        op_t              op;
        logic [LED_W-1:0] idx;
        logic [PIX_W-1:0] grb;
    } cmd_t;

    // Return SPI byte number sel (0..4) of the 40-bit code for one colour byte.
    function automatic logic [7:0] expand_colour(input logic [7:0] colour,
                                                 input logic [2:0] sel);
        logic [39:0] code;
        logic [7:0]  res;
        for (int i = 0; i < 8; i++)
        begin
            code[39-5*i -: 5] = colour[7-i] ? CODE_ONE : CODE_ZERO;
        end
        case (sel)
            3'd0:    res = code[39:32];
            3'd1:    res = code[31:24];
            3'd2:    res = code[23:16];
            3'd3:    res = code[15:8];
            3'd4:    res = code[7:0];
            default: res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== sv/ws_enc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ws_enc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/ws_enc_front.sv =====
// Front end: accepts input beats, decodes them into commands and queues them.
module ws_enc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [5:0]          pixel_index,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    output logic                q_valid,
    output ws_enc_pkg::cmd_t    q_cmd,
    input  logic                q_pop
);
    import ws_enc_pkg::*;

    cmd_t               q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    cmd_t               cmd;
    logic               in_range;
    logic               accept;
    logic               push;

    assign in_stall = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign accept   = in_valid && !in_stall;
    assign in_range = (32'(pixel_index) < LED_COUNT);

    always_comb
    begin
        cmd.op  = op_t'(operation);
        cmd.idx = LED_W'(pixel_index);
        cmd.grb = {green, red, blue};
    end

    // Drop out-of-range pixel writes here; they never reach the back end.
    assign push = accept && !((cmd.op == OP_SET) && !in_range);

    assign q_valid = (count_reg != '0);
    assign q_cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// ===== sv/ws_enc_back.sv =====
// Back end: executes queued commands, owns the pixel store and the frame sequencer.
module ws_enc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ws_enc_pkg::cmd_t    q_cmd,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          spi_byte,
    output logic [1:0]          frame_phase,
    output logic                last_of_frame
);
    import ws_enc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FETCH = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic               active_reg, active_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [1:0]         csel_reg, csel_next;
    logic [2:0]         sub_reg, sub_next;
    logic [LED_COUNT-1:0] vbits_reg, vbits_next;
    logic               vld_q_reg;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         byte_reg, byte_next;
    phase_t             oph_reg, oph_next;
    logic               last_reg, last_next;

    logic               wr_en;
    logic [PIX_W-1:0]   rd_data;
    logic [PIX_W-1:0]   px;
    logic [7:0]         colour;
    logic [7:0]         data_byte;
    logic [7:0]         len_m1;
    logic               out_free;

    ws_enc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LED_COUNT)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (q_cmd.idx),
        .wr_data (q_cmd.grb),
        .rd_addr (led_reg),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // An entry never written since the last clear reads as black.
    assign px = vld_q_reg ? rd_data : '0;

    always_comb
    begin
        case (csel_reg)
            2'd0:    colour = px[23:16];
            2'd1:    colour = px[15:8];
            2'd2:    colour = px[7:0];
            default: colour = 8'd0;
        endcase
    end

    assign data_byte = expand_colour(colour, sub_reg);

    always_comb
    begin
        case (phase_reg)
            PH_PREAMBLE: len_m1 = 8'(PREAMBLE_BYTES - 1);
            PH_LEAD:     len_m1 = 8'(LEAD_ZERO_BYTES - 1);
            default:     len_m1 = 8'(TRAIL_ZERO_BYTES - 1);
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        led_next    = led_reg;
        csel_next   = csel_reg;
        sub_next    = sub_reg;
        vbits_next  = vbits_reg;
        q_pop       = 1'b0;
        wr_en       = 1'b0;
        byte_next   = byte_reg;
        oph_next    = oph_reg;
        last_next   = last_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_SET:
                        begin
                            if (!active_reg)
                            begin
                                wr_en = 1'b1;
                                vbits_next[q_cmd.idx] = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (!active_reg)
                            begin
                                vbits_next = '0;
                            end
                        end
                        OP_SHOW:
                        begin
                            if (!active_reg)
                            begin
                                active_next = 1'b1;
                                phase_next  = PH_PREAMBLE;
                                cnt_next    = '0;
                                led_next    = '0;
                                csel_next   = '0;
                                sub_next    = '0;
                            end
                        end
                        OP_FETCH:
                        begin
                            if (active_reg)
                            begin
                                if (phase_reg == PH_DATA)
                                begin
                                    // wait in ST_FETCH for the registered store read
                                    state_next = ST_FETCH;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    byte_next = (phase_reg == PH_PREAMBLE) ?
                                                PREAMBLE_VALUE : 8'd0;
                                    oph_next  = phase_reg;
                                    last_next = 1'b0;
                                    if (cnt_reg == len_m1)
                                    begin
                                        cnt_next = '0;
                                        if (phase_reg == PH_TRAIL)
                                        begin
                                            last_next   = 1'b1;
                                            active_next = 1'b0;
                                            phase_next  = PH_PREAMBLE;
                                        end
                                        else
                                        begin
                                            phase_next = phase_t'(phase_reg + 2'd1);
                                        end
                                    end
                                    else
                                    begin
                                        cnt_next = cnt_reg + 8'd1;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
                byte_next      = data_byte;
                oph_next       = PH_DATA;
                last_next      = 1'b0;
                // advance bit group, then colour, then LED
                if (sub_reg == LAST_SUB)
                begin
                    sub_next = '0;
                    if (csel_reg == LAST_COLOUR)
                    begin
                        csel_next = '0;
                        if (32'(led_reg) == LED_COUNT - 1)
                        begin
                            led_next   = '0;
                            phase_next = PH_TRAIL;
                        end
                        else
                        begin
                            led_next = led_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        csel_next = csel_reg + 2'd1;
                    end
                end
                else
                begin
                    sub_next = sub_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            phase_reg     <= PH_PREAMBLE;
            cnt_reg       <= '0;
            led_reg       <= '0;
            csel_reg      <= '0;
            sub_reg       <= '0;
            vbits_reg     <= '0;
            vld_q_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            led_reg       <= led_next;
            csel_reg      <= csel_next;
            sub_reg       <= sub_next;
            vbits_reg     <= vbits_next;
            vld_q_reg     <= vbits_reg[led_reg];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        oph_reg  <= oph_next;
        last_reg <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign spi_byte      = byte_reg;
    assign frame_phase   = oph_reg;
    assign last_of_frame = last_reg;

endmodule

// ===== sv/ws2812_spi_frame_encoder.sv =====
// Top level of the WS2812 SPI frame encoder: front end, command queue and back end.
//
// Input channel (in_valid / in_stall) carries one command beat: set pixel, clear
// all, start frame or fetch next byte. Output channel (out_valid / out_stall)
// carries one SPI byte beat with its frame phase and an end-of-frame flag.
// Only a fetch during a frame produces an output beat; all other beats are
// absorbed, and set, clear and start are dropped while a frame is running.
// A two-entry command queue sits between the front end and the back end.
// A fetch in the preamble or zero phases writes its byte straight into the output
// register; a fetch in the pixel data phase first passes through ST_FETCH, since
// the back end waits for the registered read of the 64-entry pixel RAM.
// Set, clear, start and non-data fetches go at one beat per cycle while the
// receiver does not stall; no new command is taken while a data byte is fetched.
// Reset clears the control state and per-LED valid flags at once, so the
// pixel store reads as all black immediately; no clearing pass is needed.
// When the receiver stalls, the output register holds its byte, the back end
// stops draining the queue and in_stall rises once the queue is full.
module ws2812_spi_frame_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [5:0] pixel_index,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] spi_byte,
    output logic [1:0] frame_phase,
    output logic       last_of_frame
);
    import ws_enc_pkg::*;

    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    ws_enc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    ws_enc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .spi_byte      (spi_byte),
        .frame_phase   (frame_phase),
        .last_of_frame (last_of_frame)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty command queue");

    a_last_in_trail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_frame) |-> (frame_phase == PH_TRAIL))
        else $error("end-of-frame flag outside the trailing zero phase");

    a_preamble_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (frame_phase == PH_PREAMBLE)) |-> (spi_byte == PREAMBLE_VALUE))
        else $error("preamble byte has the wrong value");

    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((frame_phase == PH_LEAD) || (frame_phase == PH_TRAIL)))
            |-> (spi_byte == 8'd0))
        else $error("reset-phase byte is not zero");

endmodule
